// ===== design/clnw_pkg.sv =====
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types and constants for the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;
   localparam int NUM_W  = 32;
   localparam int ROW_W  = 2;
   localparam int COL_W  = 6;
   localparam int NIB_W  = 4;

   // most nibbles one request may produce
   localparam int RESULT_CAP = 24;
   localparam int NCNT_W     = 5;

   localparam logic [CMD_W-1:0] CMD_INSTR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DATA    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DATA_AT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NUM     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NUM_AT  = 3'd4;

   localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd1;
   localparam logic [ROW_W-1:0] ROW_SECOND = 2'd2;

   localparam logic [BYTE_W-1:0] ROW_BASE_1  = 8'h80;
   localparam logic [BYTE_W-1:0] ROW_BASE_2  = 8'hC0;
   localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;

   // floor(n / 10) = (n * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit n
   localparam logic [NUM_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int               DIV10_SHIFT = 35;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV_MUL,
      ST_DIV_REM,
      ST_CURSOR,
      ST_BYTE,
      ST_DIGITS,
      ST_SPACE
   } state_type;

   typedef enum logic [1:0] {
      SRC_CURSOR,
      SRC_BYTE,
      SRC_DIGIT,
      SRC_SPACE
   } src_type;

   typedef struct packed {
      logic    load;
      logic    div_mul;
      logic    div_rem;
      logic    emit;
      src_type src;
      logic    final_nib;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             placed;
      logic             conv_more;
      logic             dig_one;
      logic             half_lo;
      logic             cap_hit;
      logic             out_free;
   } dp_status_type;

endpackage

// ===== design/clnw_if.sv =====
// ----------------------------------------------------------------------------
// clnw_req_if / clnw_rsp_if
// Request and nibble channels of the character LCD nibble writer.
// ----------------------------------------------------------------------------
interface clnw_req_if;
   logic                          valid;
   logic                          ready;
   logic [clnw_pkg::CMD_W-1:0]    command;
   logic [clnw_pkg::BYTE_W-1:0]   byte_value;
   logic [clnw_pkg::NUM_W-1:0]    number_value;
   logic [clnw_pkg::ROW_W-1:0]    row;
   logic [clnw_pkg::COL_W-1:0]    column;

   modport source (output valid, command, byte_value, number_value, row, column,
                   input ready);
   modport sink   (input valid, command, byte_value, number_value, row, column,
                   output ready);
endinterface

interface clnw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        register_select;
   logic [clnw_pkg::NIB_W-1:0]  nibble;
   logic                        last;

   modport source (output valid, register_select, nibble, last, input ready);
   modport sink   (input valid, register_select, nibble, last, output ready);
endinterface

// ===== design/clnw_ctrl.sv =====
// ----------------------------------------------------------------------------
// clnw_ctrl
// Sequencer: walks a request through conversion, cursor, byte, digits, space.
// ----------------------------------------------------------------------------
module clnw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output clnw_pkg::dp_cmd_type     dp_cmd,
   input  clnw_pkg::dp_status_type  dp_status
);
   import clnw_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      last_nib;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign last_nib = dp_cmd.final_nib | dp_status.cap_hit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (dp_status.command)
               CMD_NUM, CMD_NUM_AT: state_in = ST_DIV_MUL;
               CMD_DATA_AT:         state_in = dp_status.placed ? ST_CURSOR : ST_BYTE;
               CMD_INSTR, CMD_DATA: state_in = ST_BYTE;
               default:             state_in = ST_IDLE;
            endcase
         end
         ST_DIV_MUL: begin
            state_in = ST_DIV_REM;
         end
         ST_DIV_REM: begin
            if (dp_status.conv_more) begin
               state_in = ST_DIV_MUL;
            end else if (dp_status.command == CMD_NUM_AT && dp_status.placed) begin
               state_in = ST_CURSOR;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_CURSOR, ST_BYTE, ST_DIGITS, ST_SPACE: begin
            if (dp_cmd.emit && dp_status.half_lo) begin
               if (last_nib) begin
                  state_in = ST_IDLE;
               end else if (state_ff == ST_CURSOR) begin
                  state_in = (dp_status.command == CMD_DATA_AT) ? ST_BYTE : ST_DIGITS;
               end else if (state_ff == ST_DIGITS && dp_status.dig_one) begin
                  state_in = ST_SPACE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      dp_cmd.load       = 1'b0;
      dp_cmd.div_mul    = 1'b0;
      dp_cmd.div_rem    = 1'b0;
      dp_cmd.emit       = 1'b0;
      dp_cmd.src        = SRC_BYTE;
      dp_cmd.final_nib  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
         end
         ST_DIV_MUL: begin
            dp_cmd.div_mul = 1'b1;
         end
         ST_DIV_REM: begin
            dp_cmd.div_rem = 1'b1;
         end
         ST_CURSOR: begin
            dp_cmd.emit = dp_status.out_free;
            dp_cmd.src  = SRC_CURSOR;
         end
         ST_BYTE: begin
            dp_cmd.emit      = dp_status.out_free;
            dp_cmd.src       = SRC_BYTE;
            dp_cmd.final_nib = dp_status.half_lo;
         end
         ST_DIGITS: begin
            dp_cmd.emit      = dp_status.out_free;
            dp_cmd.src       = SRC_DIGIT;
            dp_cmd.final_nib = dp_status.half_lo & dp_status.dig_one &
                               (dp_status.command != CMD_NUM_AT);
         end
         ST_SPACE: begin
            dp_cmd.emit      = dp_status.out_free;
            dp_cmd.src       = SRC_SPACE;
            dp_cmd.final_nib = dp_status.half_lo;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/clnw_dpath.sv =====
// ----------------------------------------------------------------------------
// clnw_dpath
// Request registers, divide-by-ten unit, digit store and output register.
// ----------------------------------------------------------------------------
module clnw_dpath #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [clnw_pkg::CMD_W-1:0]      req_command,
   input  logic [clnw_pkg::BYTE_W-1:0]     req_byte_value,
   input  logic [clnw_pkg::NUM_W-1:0]      req_number_value,
   input  logic [clnw_pkg::ROW_W-1:0]      req_row,
   input  logic [clnw_pkg::COL_W-1:0]      req_column,
   input  clnw_pkg::dp_cmd_type            dp_cmd,
   output clnw_pkg::dp_status_type         dp_status,
   clnw_rsp_if.source                      rsp_bus
);
   import clnw_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [CMD_W-1:0]  cmd_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [NUM_W-1:0]  value_ff;
   logic [NUM_W-1:0]  quot_ff;
   logic [CNT_W-1:0]  dig_cnt_ff;
   logic [NIB_W-1:0]  digits_ff [MAX_DIGITS];
   logic              half_ff;
   logic [NCNT_W-1:0] ncnt_ff;
   logic              rsp_valid_ff;
   logic              rs_ff;
   logic [NIB_W-1:0]  nib_ff;
   logic              last_ff;

   logic [2*NUM_W-1:0] prod;
   logic [NUM_W-1:0]   rem;
   logic [CNT_W-1:0]   rd_cnt;
   logic [IDX_W-1:0]   rd_idx;
   logic [BYTE_W-1:0]  cursor_addr;
   logic [BYTE_W-1:0]  out_byte;
   logic               out_free;

   assign prod = 64'(value_ff) * 64'(DIV10_RECIP);
   assign rem  = value_ff - ((quot_ff << 3) + (quot_ff << 1));

   assign rd_cnt = dig_cnt_ff - CNT_W'(1);
   assign rd_idx = rd_cnt[IDX_W-1:0];

   assign cursor_addr = ((row_ff == ROW_FIRST) ? ROW_BASE_1 : ROW_BASE_2)
                        + {{(BYTE_W-COL_W){1'b0}}, col_ff} - BYTE_W'(1);

   always_comb begin
      case (dp_cmd.src)
         SRC_CURSOR: out_byte = cursor_addr;
         SRC_BYTE:   out_byte = byte_ff;
         SRC_DIGIT:  out_byte = ASCII_ZERO + {{(BYTE_W-NIB_W){1'b0}}, digits_ff[rd_idx]};
         SRC_SPACE:  out_byte = ASCII_SPACE;
         default:    out_byte = byte_ff;
      endcase
   end

   assign out_free = ~rsp_valid_ff | rsp_bus.ready;

   // request registers and decimal conversion
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff     <= req_command;
         byte_ff    <= req_byte_value;
         row_ff     <= req_row;
         col_ff     <= req_column;
         value_ff   <= req_number_value;
         dig_cnt_ff <= '0;
      end else if (dp_cmd.div_mul) begin
         quot_ff <= NUM_W'(prod[2*NUM_W-1:DIV10_SHIFT]);
      end else if (dp_cmd.div_rem) begin
         digits_ff[dig_cnt_ff[IDX_W-1:0]] <= rem[NIB_W-1:0];
         value_ff   <= quot_ff;
         dig_cnt_ff <= dig_cnt_ff + CNT_W'(1);
      end else if (dp_cmd.emit && half_ff && dp_cmd.src == SRC_DIGIT) begin
         dig_cnt_ff <= rd_cnt;
      end
   end

   // nibble sequencing and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
         ncnt_ff      <= '0;
      end else begin
         if (dp_cmd.load) begin
            half_ff <= 1'b0;
            ncnt_ff <= '0;
         end else if (dp_cmd.emit) begin
            half_ff <= ~half_ff;
            ncnt_ff <= ncnt_ff + NCNT_W'(1);
         end
         // drop the valid once the sink takes the transfer
         if (dp_cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         rs_ff   <= (dp_cmd.src != SRC_CURSOR) && (cmd_ff != CMD_INSTR);
         nib_ff  <= half_ff ? out_byte[NIB_W-1:0] : out_byte[BYTE_W-1:NIB_W];
         last_ff <= dp_cmd.final_nib | dp_status.cap_hit;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.register_select = rs_ff;
   assign rsp_bus.nibble          = nib_ff;
   assign rsp_bus.last            = last_ff;

   assign dp_status.command   = cmd_ff;
   assign dp_status.placed    = (row_ff == ROW_FIRST) | (row_ff == ROW_SECOND);
   assign dp_status.conv_more = (quot_ff != '0) &&
                                (dig_cnt_ff < CNT_W'(MAX_DIGITS - 1));
   assign dp_status.dig_one   = (dig_cnt_ff == CNT_W'(1));
   assign dp_status.half_lo   = half_ff;
   assign dp_status.cap_hit   = (ncnt_ff == NCNT_W'(RESULT_CAP - 1));
   assign dp_status.out_free  = out_free;

endmodule

// ===== design/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Request-to-nibble writer for a character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// One request is taken at a time; the next is accepted once the last nibble
// of the current one sits in the output register. A request is first
// decoded, then, for number requests, each decimal digit passes through the
// shared divide-by-ten unit (a 32x32 reciprocal multiply, then the
// remainder), then one nibble goes out per cycle while the sink takes every
// transfer. Bytes go out high nibble first; a request never produces more
// than 24 nibbles, and the nibble flagged last closes it. Digits beyond
// MAX_DIGITS (most significant first) are dropped.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer #(
   parameter int MAX_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   clnw_req_if.sink    req_bus,
   clnw_rsp_if.source  rsp_bus
);
   import clnw_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   clnw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   clnw_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_bus.command),
      .req_byte_value   (req_bus.byte_value),
      .req_number_value (req_bus.number_value),
      .req_row          (req_bus.row),
      .req_column       (req_bus.column),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .rsp_bus          (rsp_bus)
   );

endmodule
